FILE: src/stli_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted table lookup interpolator.
// Table sizing, request and status codes, and the sequencer state type. No dependencies.
package stli_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = IDX_W + 1;
	localparam int DIV_STEPS   = 66;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		REQ_LOAD     = 2'd0,
		REQ_INTERP   = 2'd1,
		REQ_EXACT    = 2'd2,
		REQ_INTERVAL = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OUT_OF_RANGE = 3'd1,
		ST_NOT_KEY     = 3'd2,
		ST_EMPTY       = 3'd3,
		ST_EQUAL       = 3'd4,
		ST_LOAD_ORDER  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_RD,
		S_LD_WR,
		S_SR_ADDR,
		S_SR_CMP,
		S_LK_CHK,
		S_IP_SUB,
		S_IP_MUL,
		S_IP_DIV,
		S_IP_SUM,
		S_DONE
	} fsm_t;

endpackage

FILE: src/sorted_table_lookup_interpolator.sv
`timescale 1ns / 1ps
// Sorted table lookup interpolator: breakpoint tables, binary search sequencer,
// serial divider and output register. Depends on stli_pkg.

// Holds up to 1024 (key, value) breakpoints in signed Q16.16. One request is
// worked at a time; in_stall is high except in idle. After reset a clearing
// pass wipes the per-entry written flags, and no request is taken during it
// (table_length writes are taken at any time). A load reads the previous
// entry and then writes; a lookup runs a halving search of an address and
// a compare state per step (one memory read per step), an exact lookup then
// reads and checks the found entry; an interpolated lookup adds a product
// step and a restoring divider that yields one quotient bit per cycle for a
// 66-bit quotient. An interval search runs two searches. The finished result
// sits in an output register, so the next request may be taken while it
// waits on out_stall.
module sorted_table_lookup_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [stli_pkg::LEN_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [stli_pkg::IDX_W-1:0]    entry_index,
	input  logic signed [31:0]            key_a,
	input  logic signed [31:0]            key_b,
	input  logic signed [31:0]            load_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic signed [31:0]            result_value,
	output logic [stli_pkg::IDX_W-1:0]    first_index,
	output logic [stli_pkg::LEN_W-1:0]    span_length
);

	localparam int IW = stli_pkg::IDX_W;
	localparam int LW = stli_pkg::LEN_W;
	localparam int CNT_W_L = stli_pkg::CNT_W;

	// breakpoint storage and written flags
	logic [31:0] key_mem   [stli_pkg::TABLE_DEPTH];
	logic [31:0] val_mem   [stli_pkg::TABLE_DEPTH];
	logic        wflag_mem [stli_pkg::TABLE_DEPTH];

	stli_pkg::fsm_t state_q, state_d;

	logic [LW-1:0]      tlen_q;
	logic [LW-1:0]      used_len;
	logic [IW-1:0]      clr_q;

	// latched request
	stli_pkg::req_t     req_q;
	logic [IW-1:0]      idx_q;
	logic signed [31:0] a_q;
	logic signed [31:0] hi_key_q;
	logic [31:0]        ldval_q;

	// search unit
	logic signed [31:0] x_q;
	logic               upper_q;
	logic               second_q;
	logic [LW-1:0]      lo_q;
	logic [LW-1:0]      n_q;
	logic [LW-1:0]      lo_first_q;
	logic [LW-1:0]      half;
	logic [LW-1:0]      mid;
	logic               go_right;

	// memory access
	logic [IW-1:0]      rd_addr;
	logic               rd_en;
	logic signed [31:0] rd_key_q;
	logic signed [31:0] rd_val_q;
	logic               rd_wflag_q;
	logic               wr_tab;
	logic               wr_flag;
	logic [IW-1:0]      wr_flag_addr;
	logic               wr_flag_data;

	// interpolation datapath
	logic signed [31:0] y0_q;
	logic [32:0]        mdy_q, mt_q, mdx_q;
	logic               neg_q;
	logic [65:0]        quo_q;
	logic [33:0]        rem_q;
	logic [34:0]        rem_sh;
	logic [CNT_W_L-1:0] cnt_q;

	logic [33:0]        qc;
	logic signed [35:0] sum_w;

	// result under construction
	logic [2:0]         st_q;
	logic signed [31:0] val_q;
	logic [IW-1:0]      first_q;
	logic [LW-1:0]      span_q;

	// output register
	logic               ovalid_q;
	logic [2:0]         ostat_q;
	logic signed [31:0] oval_q;
	logic [IW-1:0]      ofirst_q;
	logic [LW-1:0]      ospan_q;
	logic               out_load;

	assign used_len = (tlen_q > LW'(stli_pkg::TABLE_DEPTH)) ? LW'(stli_pkg::TABLE_DEPTH) : tlen_q;
	assign half     = n_q >> 1;
	assign mid      = lo_q + half;
	assign go_right = upper_q ? (rd_key_q <= x_q) : (rd_key_q < x_q);

	assign in_stall = (state_q != stli_pkg::S_IDLE);
	assign out_load = (state_q == stli_pkg::S_DONE) && (!ovalid_q || !out_stall);

	assign rem_sh = {rem_q, quo_q[65]};
	assign qc     = (quo_q > 66'h2_0000_0000) ? 34'h2_0000_0000 : quo_q[33:0];
	assign sum_w  = neg_q ? (36'(y0_q) - 36'(qc)) : (36'(y0_q) + 36'(qc));

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
		end else if (cfg_wr_en) begin
			tlen_q <= cfg_wr_data;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d      = state_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_tab       = 1'b0;
		wr_flag      = 1'b0;
		wr_flag_addr = idx_q;
		wr_flag_data = 1'b1;
		case (state_q)
			stli_pkg::S_CLEAR: begin
				wr_flag      = 1'b1;
				wr_flag_addr = clr_q;
				wr_flag_data = 1'b0;
				if (clr_q == IW'(stli_pkg::TABLE_DEPTH - 1)) state_d = stli_pkg::S_IDLE;
			end
			stli_pkg::S_IDLE: begin
				if (in_valid) begin
					case (stli_pkg::req_t'(req_type))
						stli_pkg::REQ_LOAD:     state_d = stli_pkg::S_LD_RD;
						stli_pkg::REQ_INTERVAL: state_d = (key_a == key_b) ?
							stli_pkg::S_DONE : stli_pkg::S_SR_ADDR;
						default:                state_d = stli_pkg::S_SR_ADDR;
					endcase
				end
			end
			stli_pkg::S_LD_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q - IW'(1);
				state_d = stli_pkg::S_LD_WR;
			end
			stli_pkg::S_LD_WR: begin
				wr_tab  = 1'b1;
				wr_flag = 1'b1;
				state_d = stli_pkg::S_DONE;
			end
			stli_pkg::S_SR_ADDR: begin
				if (n_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = mid[IW-1:0];
					state_d = stli_pkg::S_SR_CMP;
				end else if (req_q == stli_pkg::REQ_INTERVAL) begin
					state_d = second_q ? stli_pkg::S_DONE : stli_pkg::S_SR_ADDR;
				end else if (lo_q >= used_len) begin
					state_d = stli_pkg::S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = lo_q[IW-1:0];
					state_d = stli_pkg::S_LK_CHK;
				end
			end
			stli_pkg::S_SR_CMP: state_d = stli_pkg::S_SR_ADDR;
			stli_pkg::S_LK_CHK: begin
				if (rd_key_q == a_q || req_q == stli_pkg::REQ_EXACT || lo_q == '0) begin
					state_d = stli_pkg::S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = lo_q[IW-1:0] - IW'(1);
					state_d = stli_pkg::S_IP_SUB;
				end
			end
			stli_pkg::S_IP_SUB: state_d = (rd_key_q == x_q) ? stli_pkg::S_DONE : stli_pkg::S_IP_MUL;
			stli_pkg::S_IP_MUL: state_d = stli_pkg::S_IP_DIV;
			stli_pkg::S_IP_DIV: begin
				if (cnt_q == '0) state_d = stli_pkg::S_IP_SUM;
			end
			stli_pkg::S_IP_SUM: state_d = stli_pkg::S_DONE;
			stli_pkg::S_DONE: begin
				if (out_load) state_d = stli_pkg::S_IDLE;
			end
			default: state_d = stli_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stli_pkg::S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == stli_pkg::S_CLEAR) clr_q <= clr_q + IW'(1);
		end
	end

	// tables: one read port, one write port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q   <= key_mem[rd_addr];
			rd_val_q   <= val_mem[rd_addr];
			rd_wflag_q <= wflag_mem[rd_addr];
		end
		if (wr_tab) begin
			key_mem[idx_q] <= a_q;
			val_mem[idx_q] <= ldval_q;
		end
		if (wr_flag) wflag_mem[wr_flag_addr] <= wr_flag_data;
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			stli_pkg::S_IDLE: begin
				req_q    <= stli_pkg::req_t'(req_type);
				idx_q    <= entry_index;
				a_q      <= key_a;
				ldval_q  <= load_value;
				hi_key_q <= (key_a < key_b) ? key_b : key_a;
				x_q      <= (req_type == stli_pkg::REQ_INTERVAL && key_b < key_a) ? key_b : key_a;
				upper_q  <= 1'b0;
				second_q <= 1'b0;
				lo_q     <= '0;
				n_q      <= used_len;
				st_q     <= (req_type == stli_pkg::REQ_INTERVAL && key_a == key_b) ?
					stli_pkg::ST_EQUAL : stli_pkg::ST_OK;
				val_q    <= '0;
				first_q  <= '0;
				span_q   <= '0;
			end
			stli_pkg::S_LD_WR: begin
				if (idx_q != '0 && rd_wflag_q && a_q <= rd_key_q) st_q <= stli_pkg::ST_LOAD_ORDER;
			end
			stli_pkg::S_SR_ADDR: begin
				if (n_q == '0) begin
					if (req_q == stli_pkg::REQ_INTERVAL) begin
						if (!second_q) begin
							lo_first_q <= lo_q;
							x_q        <= hi_key_q;
							upper_q    <= 1'b1;
							second_q   <= 1'b1;
							lo_q       <= '0;
							n_q        <= used_len;
						end else if (lo_q <= lo_first_q) begin
							st_q <= stli_pkg::ST_EMPTY;
						end else begin
							first_q <= lo_first_q[IW-1:0];
							span_q  <= lo_q - lo_first_q;
						end
					end else if (lo_q >= used_len) begin
						st_q <= stli_pkg::ST_OUT_OF_RANGE;
					end
				end
			end
			stli_pkg::S_SR_CMP: begin
				if (go_right) begin
					lo_q <= mid + LW'(1);
					n_q  <= n_q - half - LW'(1);
				end else begin
					n_q <= half;
				end
			end
			stli_pkg::S_LK_CHK: begin
				// keep x1, y1 of the upper breakpoint
				if (rd_key_q == a_q) begin
					val_q <= rd_val_q;
				end else if (req_q == stli_pkg::REQ_EXACT) begin
					st_q <= stli_pkg::ST_NOT_KEY;
				end else if (lo_q == '0) begin
					st_q <= stli_pkg::ST_OUT_OF_RANGE;
				end else begin
					x_q  <= rd_key_q;
					y0_q <= rd_val_q;
				end
			end
			stli_pkg::S_IP_SUB: begin
				// here x_q = x1, y0_q = y1; read data is x0, y0
				if (rd_key_q == x_q) begin
					val_q <= rd_val_q;
				end else begin
					mdx_q <= (x_q < rd_key_q) ? 33'(rd_key_q) - 33'(x_q) : 33'(x_q) - 33'(rd_key_q);
					mdy_q <= (y0_q < rd_val_q) ? 33'(rd_val_q) - 33'(y0_q) : 33'(y0_q) - 33'(rd_val_q);
					mt_q  <= (a_q < rd_key_q) ? 33'(rd_key_q) - 33'(a_q) : 33'(a_q) - 33'(rd_key_q);
					neg_q <= ((y0_q < rd_val_q) != (a_q < rd_key_q)) != (x_q < rd_key_q);
					y0_q  <= rd_val_q;
				end
			end
			stli_pkg::S_IP_MUL: begin
				quo_q <= mdy_q * mt_q;
				rem_q <= '0;
				cnt_q <= CNT_W_L'(stli_pkg::DIV_STEPS - 1);
			end
			stli_pkg::S_IP_DIV: begin
				// restoring division, one quotient bit per cycle
				if (rem_sh >= 35'(mdx_q)) begin
					rem_q <= 34'(rem_sh - 35'(mdx_q));
					quo_q <= {quo_q[64:0], 1'b1};
				end else begin
					rem_q <= rem_sh[33:0];
					quo_q <= {quo_q[64:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W_L'(1);
			end
			stli_pkg::S_IP_SUM: begin
				if (sum_w > 36'sd2147483647)        val_q <= 32'sh7FFF_FFFF;
				else if (sum_w < -36'sd2147483648)  val_q <= 32'sh8000_0000;
				else                                val_q <= sum_w[31:0];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ostat_q  <= st_q;
			oval_q   <= val_q;
			ofirst_q <= first_q;
			ospan_q  <= span_q;
		end
	end

	assign out_valid    = ovalid_q;
	assign status       = ostat_q;
	assign result_value = oval_q;
	assign first_index  = ofirst_q;
	assign span_length  = ospan_q;

endmodule
